// ===== hdl/crcf_pkg.sv =====
// crcf_pkg: shared constants for the clock ratio continued-fraction block.
// Used by the top level and the port checker. No dependencies.
package crcf_pkg;

  // Default sizing of the expansion
  localparam int MAX_TERMS_DEF   = 20;
  localparam int NUM_LIMIT_DEF   = 4096;
  localparam int DEN_LIMIT_DEF   = 256;
  localparam int FRAC_BITS_DEF   = 16;

  // Register reset value
  localparam logic [31:0] SOURCE_CLOCK_RESET = 32'd120000000;

  // Result field widths
  localparam int DIV_FIELD_W   = 12;
  localparam int FRAC_FIELD_W  = 8;
  localparam int TERMS_FIELD_W = 5;

endpackage

// ===== hdl/crcf_div.sv =====
// crcf_div: restoring divider, one quotient bit per cycle, 32-bit divisor.
// Used by clock_ratio_continued_fraction; depends on nothing else.
module crcf_div #(
  parameter int DivdW = 48,
  parameter int QuoW  = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DivdW-1:0] dividend,
  input  logic [31:0]      divisor,
  output logic             done,
  output logic [QuoW-1:0]  quotient
);

  localparam int CntW = $clog2(DivdW + 1);

  logic [CntW-1:0]  cnt;
  logic [31:0]      part;
  logic [DivdW-1:0] dvd;
  logic [31:0]      dsr;
  logic [32:0]      shifted;
  logic             fits;
  logic [32:0]      diff;

  // part < divisor always holds, so the shifted value fits in 33 bits
  assign shifted = {part, dvd[DivdW-1]};
  assign fits    = shifted >= {1'b0, dsr};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CntW'(DivdW);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      part     <= '0;
      dvd      <= dividend;
      dsr      <= divisor;
    end else if (cnt != '0) begin
      part     <= fits ? diff[31:0] : shifted[31:0];
      dvd      <= {dvd[DivdW-2:0], 1'b0};
      quotient <= {quotient[QuoW-2:0], fits};
    end
  end

endmodule

// ===== hdl/clock_ratio_continued_fraction.sv =====
// Clock ratio search: best fraction a/b for source clock over target clock.
// Uses crcf_pkg and the iterative divider crcf_div.
//
// Each request takes one target frequency and returns one result. A zero
// target returns bad_target. Otherwise the ratio is formed in fixed point by
// the shared bit-serial divider, then each further continued-fraction term
// costs one more division for the reciprocal and a convergent rebuild over
// the stored terms through a single multiplier; the divider sets most of the
// time a request takes. The block takes no new request until its result is in
// the output register; a finished result may wait there while the next
// request is taken.
module clock_ratio_continued_fraction #(
  parameter int MaxTerms         = crcf_pkg::MAX_TERMS_DEF,
  parameter int NumeratorLimit   = crcf_pkg::NUM_LIMIT_DEF,
  parameter int DenominatorLimit = crcf_pkg::DEN_LIMIT_DEF,
  parameter int FracBits         = crcf_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] target_hz,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [crcf_pkg::DIV_FIELD_W-1:0]   divisor_minus_one,
  output logic [crcf_pkg::FRAC_FIELD_W-1:0]  fraction_minus_one,
  output logic [crcf_pkg::TERMS_FIELD_W-1:0] terms_used,
  output logic        bad_target
);

  localparam int RemW  = (2 * FracBits > 32) ? 2 * FracBits : 32;
  localparam int TermW = RemW - FracBits;
  localparam int DivdW = 32 + FracBits;
  localparam int AW    = $clog2(NumeratorLimit + 1);
  localparam int SatW  = $clog2(NumeratorLimit + 2);
  localparam int CW    = SatW + AW + 1;
  localparam int IdxW  = $clog2(MaxTerms);
  localparam int CntW  = $clog2(MaxTerms + 1);
  localparam logic [SatW-1:0]  SAT_MAX   = SatW'(NumeratorLimit + 1);
  localparam logic [DivdW-1:0] RECIP_ONE = DivdW'((64'd1 << (2 * FracBits)) - 64'd1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_TERM = 7'b0000100,
    S_RD   = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_ADD  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t            state;
  logic [31:0]       src_hz;
  logic              bad;
  logic              first;
  logic [RemW-1:0]   rem;
  logic [IdxW-1:0]   idx;
  logic [IdxW-1:0]   k;
  logic [CntW-1:0]   accepted;
  logic [AW-1:0]     a;
  logic [AW-1:0]     b;
  logic [AW-1:0]     best_num;
  logic [AW-1:0]     best_den;
  logic [SatW+AW-1:0] prod;
  logic [SatW-1:0]   rd_data;
  logic [SatW-1:0]   term_mem [MaxTerms];

  logic [TermW-1:0]    term;
  logic [SatW-1:0]     term_sat;
  logic [FracBits-1:0] frac;
  logic [CW-1:0]       sum_c;
  logic                fail;
  logic                frac_small;
  logic                last_term;
  logic [31:0]         num_m1;
  logic [31:0]         den_m1;
  logic [31:0]         acc_ext;

  logic              div_start;
  logic [DivdW-1:0]  div_dividend;
  logic [31:0]       div_divisor;
  logic              div_done;
  logic [RemW-1:0]   div_q;

  assign in_stall = (state != S_IDLE);

  // Terms above the numerator limit always fail once multiplied by a >= 1,
  // so they are stored clipped to limit+1.
  assign term       = rem[RemW-1:FracBits];
  assign term_sat   = (33'(term) > 33'(NumeratorLimit)) ? SAT_MAX : SatW'(term);
  assign frac       = rem[FracBits-1:0];
  assign sum_c      = CW'(prod) + CW'(b);
  assign fail       = (sum_c > CW'(NumeratorLimit)) || (32'(a) > 32'(DenominatorLimit));
  assign frac_small = frac < FracBits'(2);
  assign last_term  = (idx == IdxW'(MaxTerms - 1));
  assign num_m1     = 32'(best_num) - 32'd1;
  assign den_m1     = 32'(best_den) - 32'd1;
  assign acc_ext    = 32'(accepted);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = {src_hz, {FracBits{1'b0}}};
    div_divisor  = target_hz;
    if (state == S_IDLE) begin
      div_start = in_valid && (target_hz != '0);
    end else if (state == S_ADD) begin
      div_dividend = RECIP_ONE;
      div_divisor  = 32'(frac);
      div_start    = !fail && (k == '0) && !frac_small && !last_term;
    end
  end

  crcf_div #(
    .DivdW (DivdW),
    .QuoW  (RemW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Term store, registered read
  always_ff @(posedge clk) begin
    if (state == S_TERM) begin
      term_mem[idx] <= term_sat;
    end
    rd_data <= term_mem[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      src_hz    <= crcf_pkg::SOURCE_CLOCK_RESET;
      out_valid <= 1'b0;
      rem       <= '0;
      best_num  <= AW'(1);
      best_den  <= AW'(1);
      idx       <= '0;
    end else begin
      if (cfg_we) begin
        src_hz <= cfg_data;
      end
      if ((state == S_OUT) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (target_hz == '0) begin
              bad   <= 1'b1;
              state <= S_OUT;
            end else begin
              bad      <= 1'b0;
              first    <= 1'b1;
              best_num <= AW'(1);
              best_den <= AW'(1);
              accepted <= '0;
              idx      <= '0;
              state    <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            // the first quotient is truncated to 32 bits, reciprocals are exact
            rem   <= first ? RemW'(div_q[31:0]) : div_q;
            first <= 1'b0;
            state <= S_TERM;
          end
        end
        S_TERM: begin
          k     <= idx;
          a     <= AW'(1);
          b     <= '0;
          state <= S_RD;
        end
        S_RD: begin
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= rd_data * a;
          state <= S_ADD;
        end
        S_ADD: begin
          a <= sum_c[AW-1:0];
          b <= a;
          if (fail) begin
            state <= S_OUT;
          end else if (k != '0) begin
            k     <= k - 1'b1;
            state <= S_RD;
          end else begin
            best_num <= sum_c[AW-1:0];
            best_den <= a;
            accepted <= accepted + 1'b1;
            if (frac_small || last_term) begin
              state <= S_OUT;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_DIV;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result fields
  always_ff @(posedge clk) begin
    if ((state == S_OUT) && (!out_valid || !out_stall)) begin
      bad_target <= bad;
      if (bad) begin
        divisor_minus_one  <= '0;
        fraction_minus_one <= '0;
        terms_used         <= '0;
      end else begin
        divisor_minus_one  <= num_m1[crcf_pkg::DIV_FIELD_W-1:0];
        fraction_minus_one <= den_m1[crcf_pkg::FRAC_FIELD_W-1:0];
        terms_used         <= acc_ext[crcf_pkg::TERMS_FIELD_W-1:0];
      end
    end
  end

endmodule

// ===== hdl/crcf_checker.sv =====
// crcf_props: port-level checks for clock_ratio_continued_fraction.
// Uses crcf_pkg; bound to the top level at the end of this file.
module crcf_props (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [crcf_pkg::DIV_FIELD_W-1:0]   divisor_minus_one,
  input logic [crcf_pkg::FRAC_FIELD_W-1:0]  fraction_minus_one,
  input logic [crcf_pkg::TERMS_FIELD_W-1:0] terms_used,
  input logic        bad_target
);

  // one request at a time: busy right after a request is taken
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while a previous one is in flight");

  // a new result only comes out of a request in progress
  a_result_from_req: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request");

  // a zero target gives empty divider fields
  a_bad_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_target |->
      divisor_minus_one == '0 && fraction_minus_one == '0 && terms_used == '0)
    else $error("bad target with nonzero fields");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(divisor_minus_one) &&
      $stable(fraction_minus_one) && $stable(terms_used) && $stable(bad_target))
    else $error("stalled result changed");

endmodule

bind clock_ratio_continued_fraction crcf_props u_crcf_props (.*);
